[rtl/core/fbdr_pkg.sv]
// ----------------------------------------------------------------------------
// fbdr_pkg
// shared types, constants and helpers of the dirty-region framebuffer
// ----------------------------------------------------------------------------
`default_nettype none

package fbdr_pkg;

  localparam int FRAME_COLS  = 120;
  localparam int FRAME_ROWS  = 160;
  localparam int ROW_BYTES   = (FRAME_COLS + 7) / 8;
  localparam int FRAME_BYTES = ROW_BYTES * FRAME_ROWS;

  localparam int ROW_W  = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;
  localparam int BCOL_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int COL_W  = BCOL_W + 3;
  localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BIT_LEFT  = 8'h80;
  // valid bits of the last byte of a row
  localparam logic [7:0] ROW_TAIL_MASK = 8'(8'hFF << (7 - ((FRAME_COLS - 1) % 8)));

  typedef enum logic [2:0] {
    ACT_SET     = 3'd0,
    ACT_CLR     = 3'd1,
    ACT_READ    = 3'd2,
    ACT_RECT    = 3'd3,
    ACT_CLR_ALL = 3'd4,
    ACT_FILL    = 3'd5,
    ACT_PRESENT = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    OUT_PLAIN  = 2'd0,
    OUT_FULL   = 2'd1,
    OUT_REGION = 2'd2,
    OUT_SAME   = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_SET     = 3'd1,
    OP_CLR     = 3'd2,
    OP_READ    = 3'd3,
    OP_RECT    = 3'd4,
    OP_FILL0   = 3'd5,
    OP_FILL1   = 3'd6,
    OP_PRESENT = 3'd7
  } op_e;

  // decoded command: a walk over rows r0..r1 and bytes b0..b1 of each row
  typedef struct packed {
    op_e               op;
    logic [ROW_W-1:0]  r0;
    logic [ROW_W-1:0]  r1;
    logic [BCOL_W-1:0] b0;
    logic [BCOL_W-1:0] b1;
    logic [7:0]        lmask;
    logic [7:0]        rmask;
    logic [ADDR_W-1:0] base;
  } cmd_t;

  function automatic cmd_t full_cmd(op_e op);
    cmd_t c;
    c.op    = op;
    c.r0    = '0;
    c.r1    = ROW_W'(FRAME_ROWS - 1);
    c.b0    = '0;
    c.b1    = BCOL_W'(ROW_BYTES - 1);
    c.lmask = BYTE_ONES;
    c.rmask = ROW_TAIL_MASK;
    c.base  = '0;
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/fbdr_front.sv]
// ----------------------------------------------------------------------------
// fbdr_front
// decodes a command, checks bounds and clamps rectangles into a byte walk
// ----------------------------------------------------------------------------
`default_nettype none

module fbdr_front (
  input  wire logic [2:0]         action_i,
  input  wire logic signed [15:0] col_or_left_i,
  input  wire logic signed [15:0] row_or_top_i,
  input  wire logic signed [15:0] right_col_i,
  input  wire logic signed [15:0] bottom_row_i,
  output fbdr_pkg::cmd_t          cmd_o
);

  localparam logic signed [16:0] COL_MAX = 17'(fbdr_pkg::FRAME_COLS - 1);
  localparam logic signed [16:0] ROW_MAX = 17'(fbdr_pkg::FRAME_ROWS - 1);
  localparam logic signed [16:0] ZERO_S  = 17'sd0;

  logic signed [16:0] a_s, b_s, c_s, d_s;
  logic signed [16:0] cx0, cx1, cy0, cy1;
  logic               on_frame, rect_empty;
  logic [fbdr_pkg::COL_W-1:0] px_col, lx, rx;
  logic [fbdr_pkg::ROW_W-1:0] px_row, ty, by;
  logic [7:0]         px_mask;
  fbdr_pkg::cmd_t     pix_cmd, rect_cmd;

  always_comb begin
    a_s = {col_or_left_i[15], col_or_left_i};
    b_s = {row_or_top_i[15], row_or_top_i};
    c_s = {right_col_i[15], right_col_i};
    d_s = {bottom_row_i[15], bottom_row_i};

    on_frame = (a_s >= ZERO_S) && (a_s <= COL_MAX) && (b_s >= ZERO_S) && (b_s <= ROW_MAX);
    px_col   = a_s[fbdr_pkg::COL_W-1:0];
    px_row   = b_s[fbdr_pkg::ROW_W-1:0];
    px_mask  = fbdr_pkg::BIT_LEFT >> px_col[2:0];

    pix_cmd.op    = fbdr_pkg::OP_NOP;
    pix_cmd.r0    = px_row;
    pix_cmd.r1    = px_row;
    pix_cmd.b0    = px_col[fbdr_pkg::COL_W-1:3];
    pix_cmd.b1    = px_col[fbdr_pkg::COL_W-1:3];
    pix_cmd.lmask = px_mask;
    pix_cmd.rmask = px_mask;
    pix_cmd.base  = fbdr_pkg::ADDR_W'(px_row * fbdr_pkg::ROW_BYTES);

    // clamp to the frame, inverted ranges checked before clamping
    cx0 = (a_s < ZERO_S) ? ZERO_S : a_s;
    cy0 = (b_s < ZERO_S) ? ZERO_S : b_s;
    cx1 = (c_s > COL_MAX) ? COL_MAX : c_s;
    cy1 = (d_s > ROW_MAX) ? ROW_MAX : d_s;
    rect_empty = (a_s > c_s) || (b_s > d_s) || (cx0 > cx1) || (cy0 > cy1);
    lx = cx0[fbdr_pkg::COL_W-1:0];
    rx = cx1[fbdr_pkg::COL_W-1:0];
    ty = cy0[fbdr_pkg::ROW_W-1:0];
    by = cy1[fbdr_pkg::ROW_W-1:0];

    rect_cmd.op    = rect_empty ? fbdr_pkg::OP_NOP : fbdr_pkg::OP_RECT;
    rect_cmd.r0    = ty;
    rect_cmd.r1    = by;
    rect_cmd.b0    = lx[fbdr_pkg::COL_W-1:3];
    rect_cmd.b1    = rx[fbdr_pkg::COL_W-1:3];
    rect_cmd.lmask = fbdr_pkg::BYTE_ONES >> lx[2:0];
    rect_cmd.rmask = fbdr_pkg::BYTE_ONES << (3'd7 - rx[2:0]);
    rect_cmd.base  = fbdr_pkg::ADDR_W'(ty * fbdr_pkg::ROW_BYTES);

    cmd_o = pix_cmd;
    unique case (action_i)
      fbdr_pkg::ACT_SET:     cmd_o.op = on_frame ? fbdr_pkg::OP_SET : fbdr_pkg::OP_NOP;
      fbdr_pkg::ACT_CLR:     cmd_o.op = on_frame ? fbdr_pkg::OP_CLR : fbdr_pkg::OP_NOP;
      fbdr_pkg::ACT_READ:    cmd_o.op = on_frame ? fbdr_pkg::OP_READ : fbdr_pkg::OP_NOP;
      fbdr_pkg::ACT_RECT:    cmd_o = rect_cmd;
      fbdr_pkg::ACT_CLR_ALL: cmd_o = fbdr_pkg::full_cmd(fbdr_pkg::OP_FILL0);
      fbdr_pkg::ACT_FILL:    cmd_o = fbdr_pkg::full_cmd(fbdr_pkg::OP_FILL1);
      fbdr_pkg::ACT_PRESENT: cmd_o = fbdr_pkg::full_cmd(fbdr_pkg::OP_PRESENT);
      default:               cmd_o.op = fbdr_pkg::OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/fbdr_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// fbdr_cmd_fifo
// short queue of decoded commands between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module fbdr_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire fbdr_pkg::cmd_t cmd_i,
  input  wire logic           pop_i,
  output fbdr_pkg::cmd_t      cmd_o,
  output logic                empty_o,
  output logic                full_o
);

  fbdr_pkg::cmd_t                    slot_q [fbdr_pkg::FIFO_DEPTH];
  logic [fbdr_pkg::FIFO_PTR_W-1:0]   wr_q, rd_q;
  logic [fbdr_pkg::FIFO_CNT_W-1:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == fbdr_pkg::FIFO_CNT_W'(fbdr_pkg::FIFO_DEPTH));
  assign cmd_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == fbdr_pkg::FIFO_PTR_W'(fbdr_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == fbdr_pkg::FIFO_PTR_W'(fbdr_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/fbdr_back.sv]
// ----------------------------------------------------------------------------
// fbdr_back
// executes commands by walking the frame memories one byte per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fbdr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fbdr_pkg::cmd_t cmd_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_pop_o,
  output logic                init_o,
  output logic                res_valid_o,
  output logic                res_pixel_o,
  output logic [1:0]          res_outcome_o,
  output logic [6:0]          res_left_o,
  output logic [7:0]          res_top_o,
  output logic [6:0]          res_right_o,
  output logic [7:0]          res_bottom_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_TAIL = 3'b100
  } state_e;

  localparam int CW = fbdr_pkg::COL_W;
  localparam int RW = fbdr_pkg::ROW_W;
  localparam int BW = fbdr_pkg::BCOL_W;
  localparam int AW = fbdr_pkg::ADDR_W;

  logic [7:0] cur_mem  [fbdr_pkg::FRAME_BYTES];
  logic [7:0] prev_mem [fbdr_pkg::FRAME_BYTES];

  state_e          state_q, state_d;
  fbdr_pkg::cmd_t  cmd_q, cmd_d;
  logic            init_q, init_d;
  logic            first_q, first_d;
  logic            copy_q, copy_d;
  logic            full_q, full_d;
  logic [RW-1:0]   row_q, row_d;
  logic [BW-1:0]   bcol_q, bcol_d;
  logic [AW-1:0]   base_q, base_d;
  logic [AW-1:0]   rd_addr;
  logic            issue, is_last;

  logic            s2_valid_q, s2_last_q;
  logic [RW-1:0]   s2_row_q;
  logic [BW-1:0]   s2_bcol_q;
  logic [AW-1:0]   s2_addr_q;
  logic [7:0]      cur_rd_q, prev_rd_q;

  logic            dirty_q, dirty_d;
  logic [CW-1:0]   min_c_q, min_c_d, max_c_q, max_c_d;
  logic [RW-1:0]   min_r_q, min_r_d, max_r_q, max_r_d;

  logic [7:0]      mask, diff;
  logic            cur_we, prev_we;
  logic [7:0]      cur_wd;
  logic [2:0]      lo_off, hi_off;
  logic            lo_found, hi_found;
  logic            pix_d, finish, emit;
  fbdr_pkg::outcome_e outcome;

  logic            res_valid_q, res_pixel_q;
  logic [1:0]      res_outcome_q;
  logic [6:0]      res_left_q, res_right_q;
  logic [7:0]      res_top_q, res_bottom_q;

  assign rd_addr = base_q + AW'(bcol_q);
  assign issue   = (state_q == ST_RUN);
  assign is_last = (row_q == cmd_q.r1) && (bcol_q == cmd_q.b1);

  // memories: registered read, write from the second stage
  always_ff @(posedge clk_i) begin
    cur_rd_q  <= cur_mem[rd_addr];
    prev_rd_q <= prev_mem[rd_addr];
    if (cur_we) begin
      cur_mem[s2_addr_q] <= cur_wd;
    end
    if (prev_we) begin
      prev_mem[s2_addr_q] <= cur_rd_q;
    end
  end

  // second stage: byte mask, write data, bit search
  always_comb begin
    mask = ((s2_bcol_q == cmd_q.b0) ? cmd_q.lmask : fbdr_pkg::BYTE_ONES)
         & ((s2_bcol_q == cmd_q.b1) ? cmd_q.rmask : fbdr_pkg::BYTE_ONES);
    diff = (cur_rd_q ^ prev_rd_q) & mask;
    cur_we  = 1'b0;
    prev_we = s2_valid_q && copy_q;
    cur_wd  = cur_rd_q;
    if (s2_valid_q && !copy_q) begin
      unique case (cmd_q.op)
        fbdr_pkg::OP_SET:   begin cur_we = 1'b1; cur_wd = cur_rd_q | mask;  end
        fbdr_pkg::OP_CLR,
        fbdr_pkg::OP_RECT:  begin cur_we = 1'b1; cur_wd = cur_rd_q & ~mask; end
        fbdr_pkg::OP_FILL0: begin cur_we = 1'b1; cur_wd = fbdr_pkg::BYTE_ZERO; end
        fbdr_pkg::OP_FILL1: begin cur_we = 1'b1; cur_wd = fbdr_pkg::BYTE_ONES; end
        default:            cur_we = 1'b0;
      endcase
    end
    pix_d = |(cur_rd_q & mask);

    lo_off = '0;
    hi_off = '0;
    lo_found = 1'b0;
    hi_found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!lo_found && diff[7-i]) begin
        lo_found = 1'b1;
        lo_off   = 3'(i);
      end
      if (!hi_found && diff[i]) begin
        hi_found = 1'b1;
        hi_off   = 3'(7 - i);
      end
    end

    dirty_d = dirty_q;
    min_c_d = min_c_q;
    max_c_d = max_c_q;
    min_r_d = min_r_q;
    max_r_d = max_r_q;
    if (s2_valid_q && !copy_q && (cmd_q.op == fbdr_pkg::OP_PRESENT) && (diff != '0)) begin
      if (!dirty_q) begin
        dirty_d = 1'b1;
        min_c_d = {s2_bcol_q, lo_off};
        max_c_d = {s2_bcol_q, hi_off};
        min_r_d = s2_row_q;
        max_r_d = s2_row_q;
      end else begin
        if ({s2_bcol_q, lo_off} < min_c_q) min_c_d = {s2_bcol_q, lo_off};
        if ({s2_bcol_q, hi_off} > max_c_q) max_c_d = {s2_bcol_q, hi_off};
        max_r_d = s2_row_q;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    init_d    = init_q;
    first_d   = first_q;
    copy_d    = copy_q;
    full_d    = full_q;
    row_d     = row_q;
    bcol_d    = bcol_q;
    base_d    = base_q;
    cmd_pop_o = 1'b0;
    finish    = 1'b0;
    emit      = 1'b0;
    outcome   = fbdr_pkg::OUT_PLAIN;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          row_d     = cmd_i.r0;
          bcol_d    = cmd_i.b0;
          base_d    = cmd_i.base;
          copy_d    = 1'b0;
          full_d    = 1'b0;
          if (cmd_i.op == fbdr_pkg::OP_NOP) begin
            emit = 1'b1;
          end else begin
            state_d = ST_RUN;
            if (cmd_i.op == fbdr_pkg::OP_PRESENT && first_q) begin
              copy_d  = 1'b1;
              full_d  = 1'b1;
              first_d = 1'b0;
            end
          end
        end
      end
      ST_RUN: begin
        if (is_last) begin
          state_d = ST_TAIL;
        end else if (bcol_q == cmd_q.b1) begin
          bcol_d = cmd_q.b0;
          row_d  = row_q + 1'b1;
          base_d = base_q + AW'(fbdr_pkg::ROW_BYTES);
        end else begin
          bcol_d = bcol_q + 1'b1;
        end
      end
      ST_TAIL: begin
        if (s2_valid_q && s2_last_q) begin
          finish = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (finish) begin
      if (init_q) begin
        init_d  = 1'b0;
        state_d = ST_IDLE;
      end else if (cmd_q.op == fbdr_pkg::OP_PRESENT && !copy_q && dirty_d) begin
        copy_d  = 1'b1;
        row_d   = cmd_q.r0;
        bcol_d  = cmd_q.b0;
        base_d  = cmd_q.base;
        state_d = ST_RUN;
      end else begin
        emit    = 1'b1;
        state_d = ST_IDLE;
      end
    end

    if (cmd_q.op == fbdr_pkg::OP_PRESENT && state_q != ST_IDLE) begin
      if (!copy_q)     outcome = fbdr_pkg::OUT_SAME;
      else if (full_q) outcome = fbdr_pkg::OUT_FULL;
      else             outcome = fbdr_pkg::OUT_REGION;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // reset starts the clearing pass of the current frame
      state_q     <= ST_RUN;
      cmd_q       <= fbdr_pkg::full_cmd(fbdr_pkg::OP_FILL0);
      init_q      <= 1'b1;
      first_q     <= 1'b1;
      copy_q      <= 1'b0;
      full_q      <= 1'b0;
      row_q       <= '0;
      bcol_q      <= '0;
      base_q      <= '0;
      s2_valid_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      dirty_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      init_q      <= init_d;
      first_q     <= first_d;
      copy_q      <= copy_d;
      full_q      <= full_d;
      row_q       <= row_d;
      bcol_q      <= bcol_d;
      base_q      <= base_d;
      s2_valid_q  <= issue;
      s2_last_q   <= issue && is_last;
      dirty_q     <= (state_q == ST_IDLE) ? 1'b0 : dirty_d;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_row_q  <= row_q;
    s2_bcol_q <= bcol_q;
    s2_addr_q <= rd_addr;
    min_c_q   <= min_c_d;
    max_c_q   <= max_c_d;
    min_r_q   <= min_r_d;
    max_r_q   <= max_r_d;
    if (emit) begin
      res_pixel_q   <= (state_q != ST_IDLE) && (cmd_q.op == fbdr_pkg::OP_READ) && pix_d;
      res_outcome_q <= outcome;
      if (outcome == fbdr_pkg::OUT_REGION) begin
        res_left_q   <= 7'(min_c_q);
        res_right_q  <= 7'(max_c_q);
        res_top_q    <= 8'(min_r_q);
        res_bottom_q <= 8'(max_r_q);
      end else begin
        res_left_q   <= '0;
        res_right_q  <= '0;
        res_top_q    <= '0;
        res_bottom_q <= '0;
      end
    end
  end

  assign init_o        = init_q;
  assign res_valid_o   = res_valid_q;
  assign res_pixel_o   = res_pixel_q;
  assign res_outcome_o = res_outcome_q;
  assign res_left_o    = res_left_q;
  assign res_top_o     = res_top_q;
  assign res_right_o   = res_right_q;
  assign res_bottom_o  = res_bottom_q;

endmodule

`default_nettype wire

[rtl/core/framebuffer_dirty_region.sv]
// ----------------------------------------------------------------------------
// framebuffer_dirty_region
// One-bit 120 x 160 framebuffer with set, clear and read of a pixel, clamped
// rectangle clear, clear and fill of the frame, and a present that reports a
// full redraw (first present after reset), no change, or the bounding box of
// the changed pixels. A command transfers when start is high and busy is low;
// every command gives exactly one result, shown for one cycle with
// result_valid_o, and the receiver cannot stall it. After reset the frame
// memory is cleared by a pass over every byte while busy stays high. The back
// end walks the frame memory byte by byte: the single byte of a pixel command,
// the bytes of the clamped rectangle (rows times byte columns) for a rectangle
// clear, every frame byte for clear or fill, every frame byte once for the first
// present or a present with no change, and twice for a present that finds a
// change (a compare pass, then a copy pass). A command that does nothing (pixel
// off the frame, empty rectangle, undefined action) walks no bytes.
// A two-entry command queue lets the caller hand over the next commands while
// the back end works; each result is registered and comes in the cycle after
// the back end finishes its command.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_dirty_region (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         action_i,
  input  wire logic signed [15:0] col_or_left_i,
  input  wire logic signed [15:0] row_or_top_i,
  input  wire logic signed [15:0] right_col_i,
  input  wire logic signed [15:0] bottom_row_i,
  output logic                    result_valid_o,
  output logic                    pixel_value_o,
  output logic [1:0]              outcome_o,
  output logic [6:0]              box_left_o,
  output logic [7:0]              box_top_o,
  output logic [6:0]              box_right_o,
  output logic [7:0]              box_bottom_o
);

  fbdr_pkg::cmd_t dec_cmd, q_cmd;
  logic           q_empty, q_full, q_pop, back_init;

  // front end: bounds check and clamping into a byte walk
  fbdr_front u_front (
    .action_i      (action_i),
    .col_or_left_i (col_or_left_i),
    .row_or_top_i  (row_or_top_i),
    .right_col_i   (right_col_i),
    .bottom_row_i  (bottom_row_i),
    .cmd_o         (dec_cmd)
  );

  // no transfer while the queue is full or the clearing pass runs
  assign busy = q_full || back_init;

  fbdr_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start && !busy),
    .cmd_i   (dec_cmd),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back end: memory walker, snapshot copy and box search
  fbdr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (q_cmd),
    .cmd_valid_i   (!q_empty),
    .cmd_pop_o     (q_pop),
    .init_o        (back_init),
    .res_valid_o   (result_valid_o),
    .res_pixel_o   (pixel_value_o),
    .res_outcome_o (outcome_o),
    .res_left_o    (box_left_o),
    .res_top_o     (box_top_o),
    .res_right_o   (box_right_o),
    .res_bottom_o  (box_bottom_o)
  );

`ifndef SYNTHESIS
  // no result comes out of the clearing pass
  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_init |-> !result_valid_o)
    else $error("result during clearing pass");

  // a region box is never inverted
  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && outcome_o == fbdr_pkg::OUT_REGION) |->
      (box_left_o <= box_right_o) && (box_top_o <= box_bottom_o))
    else $error("inverted region box");

  // a set pixel value only comes with a plain result
  a_pixel_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && pixel_value_o) |-> (outcome_o == fbdr_pkg::OUT_PLAIN))
    else $error("pixel value on a present result");

  // the queue is never popped while empty
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command queue underflow");
`endif

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives pixel, rectangle, clear/fill and present commands into the
// dirty-region framebuffer and compares every result with a bit-level frame
// model that tracks the current frame, the presented snapshot and the box
// ----------------------------------------------------------------------------

// expected result of one command
typedef struct {
  logic                   pixel;
  fbdr_pkg::outcome_e     outcome;
  logic [6:0]             left;
  logic [7:0]             top;
  logic [6:0]             right;
  logic [7:0]             bottom;
} fb_result_t;

class fb_scoreboard;
  bit         cur_frame  [fbdr_pkg::FRAME_ROWS][fbdr_pkg::FRAME_COLS];
  bit         shown_frame[fbdr_pkg::FRAME_ROWS][fbdr_pkg::FRAME_COLS];
  bit         redraw_pending;
  fb_result_t pending_results[$];
  int         errors;
  int         region_count;
  int         same_count;

  function new();
    redraw_pending = 1;
    errors         = 0;
    region_count   = 0;
    same_count     = 0;
    foreach (cur_frame[r, c]) cur_frame[r][c] = 0;
  endfunction

  static function bit on_frame(int col, int row);
    return col >= 0 && col < fbdr_pkg::FRAME_COLS && row >= 0 && row < fbdr_pkg::FRAME_ROWS;
  endfunction

  // works out what the block returns for one accepted command
  function void note_command(logic [2:0] act, logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c, logic signed [15:0] d);
    fb_result_t res;
    int x0, y0, x1, y1;
    bit dirty;
    res = '{1'b0, fbdr_pkg::OUT_PLAIN, 7'd0, 8'd0, 7'd0, 8'd0};
    x0 = int'(a); y0 = int'(b); x1 = int'(c); y1 = int'(d);
    case (act)
      fbdr_pkg::ACT_SET:  if (on_frame(x0, y0)) cur_frame[y0][x0] = 1;
      fbdr_pkg::ACT_CLR:  if (on_frame(x0, y0)) cur_frame[y0][x0] = 0;
      fbdr_pkg::ACT_READ: if (on_frame(x0, y0)) res.pixel = cur_frame[y0][x0];
      fbdr_pkg::ACT_RECT: begin
        // inverted ranges are tested before clamping
        if (x0 <= x1 && y0 <= y1) begin
          if (x0 < 0) x0 = 0;
          if (y0 < 0) y0 = 0;
          if (x1 > fbdr_pkg::FRAME_COLS - 1) x1 = fbdr_pkg::FRAME_COLS - 1;
          if (y1 > fbdr_pkg::FRAME_ROWS - 1) y1 = fbdr_pkg::FRAME_ROWS - 1;
          for (int r = y0; r <= y1; r++)
            for (int k = x0; k <= x1; k++) cur_frame[r][k] = 0;
        end
      end
      fbdr_pkg::ACT_CLR_ALL: foreach (cur_frame[r, k]) cur_frame[r][k] = 0;
      fbdr_pkg::ACT_FILL:    foreach (cur_frame[r, k]) cur_frame[r][k] = 1;
      fbdr_pkg::ACT_PRESENT: begin
        if (redraw_pending) begin
          redraw_pending = 0;
          shown_frame = cur_frame;
          res.outcome = fbdr_pkg::OUT_FULL;
        end else begin
          dirty = 0;
          for (int r = 0; r < fbdr_pkg::FRAME_ROWS; r++)
            for (int k = 0; k < fbdr_pkg::FRAME_COLS; k++)
              if (cur_frame[r][k] != shown_frame[r][k]) begin
                if (!dirty) begin
                  res.left = 7'(k); res.right = 7'(k); res.top = 8'(r);
                  dirty = 1;
                end else begin
                  if (k < res.left)  res.left  = 7'(k);
                  if (k > res.right) res.right = 7'(k);
                end
                res.bottom = 8'(r);
              end
          if (dirty) begin
            res.outcome = fbdr_pkg::OUT_REGION;
            shown_frame = cur_frame;
            region_count++;
          end else begin
            res.outcome = fbdr_pkg::OUT_SAME;
            same_count++;
          end
        end
      end
      default: ;
    endcase
    pending_results.push_back(res);
  endfunction

  function void check_result(logic pix, logic [1:0] outc, logic [6:0] l, logic [7:0] t,
                             logic [6:0] rr, logic [7:0] bt);
    fb_result_t e;
    if (pending_results.size() == 0) begin
      $error("result with no command outstanding");
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (pix !== e.pixel) begin
      $error("pixel_value: expected %0d, got %0d", e.pixel, pix); errors++;
    end
    if (outc !== e.outcome) begin
      $error("outcome: expected %0d, got %0d", e.outcome, outc); errors++;
    end
    if (l !== e.left) begin
      $error("box_left: expected %0d, got %0d", e.left, l); errors++;
    end
    if (t !== e.top) begin
      $error("box_top: expected %0d, got %0d", e.top, t); errors++;
    end
    if (rr !== e.right) begin
      $error("box_right: expected %0d, got %0d", e.right, rr); errors++;
    end
    if (bt !== e.bottom) begin
      $error("box_bottom: expected %0d, got %0d", e.bottom, bt); errors++;
    end
  endfunction
endclass

module testbench;

  // code left undefined by the block: must do nothing
  localparam logic [2:0] ACT_UNDEF    = 3'd7;
  localparam int         RANDOM_ITEMS = 430;
  localparam longint     CYCLE_LIMIT  = 12_000_000;
  localparam int         COLS         = fbdr_pkg::FRAME_COLS;
  localparam int         ROWS         = fbdr_pkg::FRAME_ROWS;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [2:0]         action_i;
  logic signed [15:0] col_or_left_i;
  logic signed [15:0] row_or_top_i;
  logic signed [15:0] right_col_i;
  logic signed [15:0] bottom_row_i;
  logic               result_valid_o;
  logic               pixel_value_o;
  logic [1:0]         outcome_o;
  logic [6:0]         box_left_o;
  logic [7:0]         box_top_o;
  logic [6:0]         box_right_o;
  logic [7:0]         box_bottom_o;

  fb_scoreboard sb;
  longint       cycle_count;
  int           action_count[8];
  bit           idle_enabled;

  framebuffer_dirty_region u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .col_or_left_i  (col_or_left_i),
    .row_or_top_i   (row_or_top_i),
    .right_col_i    (right_col_i),
    .bottom_row_i   (bottom_row_i),
    .result_valid_o (result_valid_o),
    .pixel_value_o  (pixel_value_o),
    .outcome_o      (outcome_o),
    .box_left_o     (box_left_o),
    .box_top_o      (box_top_o),
    .box_right_o    (box_right_o),
    .box_bottom_o   (box_bottom_o)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // results cannot be held off: every strobe is a transfer
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result(pixel_value_o, outcome_o, box_left_o, box_top_o, box_right_o,
                      box_bottom_o);
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // hold one command on the ports until the block takes it; start stays high
  // unless an idle burst drops it, so the caller either sends the next command or drops start
  task automatic send_command(logic [2:0] act, int a, int b, int c, int d);
    start         <= 1'b1;
    action_i      <= act;
    col_or_left_i <= 16'(a);
    row_or_top_i  <= 16'(b);
    right_col_i   <= 16'(c);
    bottom_row_i  <= 16'(d);
    do @(posedge clk_i); while (busy);
    sb.note_command(action_i, col_or_left_i, row_or_top_i, right_col_i, bottom_row_i);
    action_count[action_i]++;
    // random idle bursts between transfers
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // coordinate: mostly on the frame, some just off it, some anywhere
  function automatic int pick_coord(int span);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) return $urandom_range(0, span - 1);
    if (sel < 90) return int'($urandom_range(0, span + 15)) - 8;
    return int'(16'($urandom));
  endfunction

  initial begin
    int sel, x, y;
    sb            = new();
    cycle_count   = 0;
    idle_enabled  = 1;
    rst_ni        = 1'b0;
    start         = 1'b0;
    action_i      = fbdr_pkg::ACT_SET;
    col_or_left_i = '0;
    row_or_top_i  = '0;
    right_col_i   = '0;
    bottom_row_i  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corners, off-frame reads, each present outcome, rectangles
    send_command(fbdr_pkg::ACT_SET, 0, 0, 0, 0);
    send_command(fbdr_pkg::ACT_SET, COLS - 1, ROWS - 1, 0, 0);
    send_command(fbdr_pkg::ACT_READ, 0, 0, 0, 0);
    send_command(fbdr_pkg::ACT_READ, COLS - 1, ROWS - 1, 0, 0);
    send_command(fbdr_pkg::ACT_READ, -1, 0, 0, 0);
    send_command(fbdr_pkg::ACT_SET, COLS, 5, 0, 0);
    send_command(fbdr_pkg::ACT_READ, 0, ROWS, 0, 0);
    send_command(fbdr_pkg::ACT_READ, -32768, 32767, -1, -1);
    send_command(fbdr_pkg::ACT_PRESENT, 0, 0, 0, 0);
    send_command(fbdr_pkg::ACT_PRESENT, 0, 0, 0, 0);
    send_command(fbdr_pkg::ACT_SET, 37, 91, 0, 0);
    send_command(fbdr_pkg::ACT_CLR, COLS - 1, ROWS - 1, 0, 0);
    send_command(fbdr_pkg::ACT_PRESENT, 0, 0, 0, 0);
    send_command(fbdr_pkg::ACT_RECT, 10, 10, 5, 20);
    send_command(fbdr_pkg::ACT_RECT, 10, 30, 20, 25);
    send_command(fbdr_pkg::ACT_RECT, 200, 5, 300, 50);
    send_command(fbdr_pkg::ACT_RECT, -32768, -32768, 32767, 32767);
    send_command(fbdr_pkg::ACT_FILL, 0, 0, 0, 0);
    send_command(fbdr_pkg::ACT_RECT, -5, 150, 9, 200);
    send_command(fbdr_pkg::ACT_PRESENT, 0, 0, 0, 0);
    send_command(fbdr_pkg::ACT_CLR_ALL, 0, 0, 0, 0);
    send_command(ACT_UNDEF, 32767, -32768, 32767, -32768);
    send_command(fbdr_pkg::ACT_PRESENT, 0, 0, 0, 0);

    // random: mostly pixel traffic, with the occasional whole-frame walk
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n > RANDOM_ITEMS - 60) idle_enabled = 0;
      sel = $urandom_range(0, 99);
      if (sel < 35)
        send_command(fbdr_pkg::ACT_SET, pick_coord(COLS), pick_coord(ROWS),
                     int'(16'($urandom)), int'(16'($urandom)));
      else if (sel < 55)
        send_command(fbdr_pkg::ACT_CLR, pick_coord(COLS), pick_coord(ROWS), 0, 0);
      else if (sel < 78)
        send_command(fbdr_pkg::ACT_READ, pick_coord(COLS), pick_coord(ROWS), 0, 0);
      else if (sel < 87) begin
        x = pick_coord(COLS);
        y = pick_coord(ROWS);
        // small rectangles keep the walk short; some are inverted or wild
        send_command(fbdr_pkg::ACT_RECT, x, y, x + int'($urandom_range(0, 20)) - 2,
                     (sel == 86) ? pick_coord(ROWS) : y + int'($urandom_range(0, 20)) - 2);
      end else if (sel < 89)
        send_command((sel == 87) ? fbdr_pkg::ACT_CLR_ALL : fbdr_pkg::ACT_FILL, 0, 0, 0, 0);
      else if (sel < 90)
        send_command(ACT_UNDEF, pick_coord(COLS), pick_coord(ROWS), 0, 0);
      else
        send_command(fbdr_pkg::ACT_PRESENT, 0, 0, 0, 0);
    end
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d set, %0d clear, %0d read, %0d rect, %0d clear-all, %0d fill,",
             action_count[fbdr_pkg::ACT_SET], action_count[fbdr_pkg::ACT_CLR],
             action_count[fbdr_pkg::ACT_READ], action_count[fbdr_pkg::ACT_RECT],
             action_count[fbdr_pkg::ACT_CLR_ALL], action_count[fbdr_pkg::ACT_FILL]);
    $display("%0d undefined and %0d presents (%0d with a box, %0d unchanged)",
             action_count[ACT_UNDEF], action_count[fbdr_pkg::ACT_PRESENT],
             sb.region_count, sb.same_count);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
